FILE: rtl/hgeb_pkg.sv
// ----------------------------------------------------------------------------
// hgeb_pkg
// Shared widths, codes and layer bounds for the hit graph edge builder.
// ----------------------------------------------------------------------------
package hgeb_pkg;

    localparam int LAYER_W   = 5;
    localparam int ANGLE_W   = 16;
    localparam int OUT_IDX_W = 6;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_W-1:0] TIGHT_WIN_RST = 16'd8192;
    localparam logic [CFG_W-1:0] WIDE_WIN_RST  = 16'd16384;

    localparam logic [LAYER_W-1:0] LYR_INNER_LO = 5'd1;
    localparam logic [LAYER_W-1:0] LYR_INNER_HI = 5'd6;
    localparam logic [LAYER_W-1:0] LYR_DRIFT_LO = 5'd7;
    localparam logic [LAYER_W-1:0] LYR_NEAR_HI  = 5'd18;
    localparam logic [LAYER_W-1:0] LYR_DRIFT_HI = 5'd23;
    localparam logic [LAYER_W-1:0] LYR_MID      = 5'd24;
    localparam logic [LAYER_W-1:0] LYR_OUTER    = 5'd25;

    typedef enum logic {
        ACT_ADD_HIT   = 1'b0,
        ACT_NEW_EVENT = 1'b1
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIGHT_WIN = 1'b0,
        CFG_WIDE_WIN  = 1'b1
    } t_cfg_idx;

endpackage

FILE: rtl/hgeb_in_if.sv
// ----------------------------------------------------------------------------
// hgeb_in_if
// Hit input channel: valid/ready handshake with action, layer and azimuth.
// ----------------------------------------------------------------------------
interface hgeb_in_if;
    import hgeb_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      action;
    logic [LAYER_W-1:0]        layer;
    logic signed [ANGLE_W-1:0] azimuth;

    modport source (output valid, action, layer, azimuth, input ready);
    modport sink   (input valid, action, layer, azimuth, output ready);
endinterface

FILE: rtl/hgeb_out_if.sv
// ----------------------------------------------------------------------------
// hgeb_out_if
// Edge output channel: valid/ready handshake with one edge or status word.
// ----------------------------------------------------------------------------
interface hgeb_out_if;
    import hgeb_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OUT_IDX_W-1:0] src_index;
    logic [OUT_IDX_W-1:0] dst_index;
    logic                 edge_valid;
    logic                 overflow;
    logic                 last;

    modport source (output valid, src_index, dst_index, edge_valid, overflow, last,
                    input ready);
    modport sink   (input valid, src_index, dst_index, edge_valid, overflow, last,
                    output ready);
endinterface

FILE: rtl/hgeb_ram.sv
// ----------------------------------------------------------------------------
// hgeb_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module hgeb_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/hit_graph_edge_builder_core.sv
// ----------------------------------------------------------------------------
// hit_graph_edge_builder_core
// Compares each new hit with the stored hits of the event and emits edges.
// ----------------------------------------------------------------------------
// Usage:
//   i_hit carries one word per hit (action, layer, azimuth). A new-event word
//   clears the hit store and gives no result. An add word is stored and
//   scanned against the N hits already in the event, one stored hit per
//   cycle unless the scan stalls, through a single pair-test unit fed by the
//   hit RAM port. An add word keeps ready low until its scan and flush are
//   done, longer while they wait on o_edge; the last edge enters the
//   output register at the edge at which ready returns.
//   o_edge gives one word per qualifying pair (src, dst) in store order,
//   last set on the final one. A hit that finds the store full gives one
//   status word with overflow set; a hit with no pair gives no word.
//   Edges pass a pending stage and an output register; the scan stalls only
//   when an edge is found while both are full and o_edge is stalled.
//   Configuration writes (tight and wide windows) are to be made while idle;
//   the core does not enforce this. Synchronous reset empties the event and
//   restores the default windows; no clearing pass is needed.
// ----------------------------------------------------------------------------
module hit_graph_edge_builder_core #(
    parameter int MAX_HITS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    hgeb_in_if.sink                          i_hit,
    hgeb_out_if.source                       o_edge,
    input  logic                             i_cfg_we,
    input  logic [hgeb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [hgeb_pkg::CFG_W-1:0]       i_cfg_data
);
    import hgeb_pkg::*;

    localparam int IDX_W  = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
    localparam int CNT_W  = $clog2(MAX_HITS + 1);
    localparam int WORD_W = LAYER_W + ANGLE_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_OVFL
    } t_state;

    t_state                    r_state;
    logic [CNT_W-1:0]          r_count;
    logic [CFG_W-1:0]          r_tight_win;
    logic [CFG_W-1:0]          r_wide_win;
    logic [LAYER_W-1:0]        r_new_layer;
    logic signed [ANGLE_W-1:0] r_new_angle;
    logic [IDX_W-1:0]          r_dst;
    logic [IDX_W-1:0]          r_rd_idx;
    logic [IDX_W-1:0]          r_cmp_idx;
    logic                      r_cmp_v;
    logic                      r_pend_valid;
    logic [IDX_W-1:0]          r_pend_src;
    logic                      r_out_valid;
    logic [IDX_W-1:0]          r_out_src;
    logic [IDX_W-1:0]          r_out_dst;
    logic                      r_out_edge;
    logic                      r_out_ovf;
    logic                      r_out_last;

    logic                      in_acc;
    logic                      store_full;
    logic                      out_free;
    logic                      ram_we;
    logic                      ram_re;
    logic [WORD_W-1:0]         ram_rdata;
    logic [LAYER_W-1:0]        old_layer;
    logic signed [ANGLE_W-1:0] old_angle;
    logic                      hit_match;
    logic                      adv;
    logic                      scan_done;

    function automatic logic in_win(input logic signed [ANGLE_W-1:0] a,
                                    input logic signed [ANGLE_W-1:0] b,
                                    input logic [CFG_W-1:0] w);
        logic signed [ANGLE_W:0] diff;
        logic [ANGLE_W:0]        d;
        logic [ANGLE_W:0]        upper;
        diff  = (ANGLE_W+1)'(a) - (ANGLE_W+1)'(b);
        d     = diff[ANGLE_W] ? (ANGLE_W+1)'(-diff) : (ANGLE_W+1)'(diff);
        upper = {1'b1, {ANGLE_W{1'b0}}} - {1'b0, w};
        return (d < {1'b0, w}) || (d > upper);
    endfunction

    function automatic logic pair_ok(input logic [LAYER_W-1:0] la,
                                     input logic signed [ANGLE_W-1:0] aa,
                                     input logic [LAYER_W-1:0] lb,
                                     input logic signed [ANGLE_W-1:0] ab,
                                     input logic [CFG_W-1:0] tight,
                                     input logic [CFG_W-1:0] wide);
        logic a_in, b_in, a_near, b_near, a_dr, b_dr, a_dh, b_dh;
        logic ok;
        a_in   = (la >= LYR_INNER_LO) && (la <= LYR_INNER_HI);
        b_in   = (lb >= LYR_INNER_LO) && (lb <= LYR_INNER_HI);
        a_near = (la >= LYR_DRIFT_LO) && (la <= LYR_NEAR_HI);
        b_near = (lb >= LYR_DRIFT_LO) && (lb <= LYR_NEAR_HI);
        a_dr   = (la >= LYR_DRIFT_LO) && (la <= LYR_MID);
        b_dr   = (lb >= LYR_DRIFT_LO) && (lb <= LYR_MID);
        a_dh   = (la >= LYR_DRIFT_LO) && (la <= LYR_DRIFT_HI);
        b_dh   = (lb >= LYR_DRIFT_LO) && (lb <= LYR_DRIFT_HI);
        if (a_in && b_in) begin
            ok = (la != lb);
        end else if ((a_in && b_near) || (b_in && a_near)) begin
            ok = 1'b1;
        end else if (a_dr && b_dr) begin
            ok = (la != lb) && in_win(aa, ab, tight);
        end else if ((la == LYR_OUTER && b_dh) || (lb == LYR_OUTER && a_dh)) begin
            ok = in_win(aa, ab, wide);
        end else begin
            ok = 1'b0;
        end
        return ok;
    endfunction

    assign in_acc     = i_hit.valid && i_hit.ready;
    assign store_full = (r_count >= CNT_W'(MAX_HITS));
    assign out_free   = !r_out_valid || o_edge.ready;
    assign ram_we     = in_acc && (i_hit.action == ACT_ADD_HIT) && !store_full;

    assign old_layer  = ram_rdata[WORD_W-1:ANGLE_W];
    assign old_angle  = ram_rdata[ANGLE_W-1:0];
    assign hit_match  = r_cmp_v && pair_ok(old_layer, old_angle, r_new_layer, r_new_angle,
                                           r_tight_win, r_wide_win);
    assign adv        = !(hit_match && r_pend_valid && !out_free);
    assign scan_done  = !r_cmp_v && (r_rd_idx == r_dst);
    assign ram_re     = (r_state == S_SCAN) && adv && (r_rd_idx != r_dst);

    hgeb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_HITS)
    ) u_hit_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata ({i_hit.layer, i_hit.azimuth}),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_tight_win  <= TIGHT_WIN_RST;
            r_wide_win   <= WIDE_WIN_RST;
            r_cmp_v      <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_edge.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_TIGHT_WIN: r_tight_win <= i_cfg_data;
                    CFG_WIDE_WIN:  r_wide_win  <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_hit.action == ACT_NEW_EVENT) begin
                            r_count <= '0;
                        end else if (store_full) begin
                            r_state <= S_OVFL;
                        end else begin
                            r_new_layer <= i_hit.layer;
                            r_new_angle <= i_hit.azimuth;
                            r_dst       <= r_count[IDX_W-1:0];
                            r_rd_idx    <= '0;
                            r_cmp_v     <= 1'b0;
                            r_count     <= r_count + CNT_W'(1);
                            r_state     <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (adv) begin
                        if (hit_match) begin
                            if (r_pend_valid) begin
                                r_out_valid <= 1'b1;
                                r_out_src   <= r_pend_src;
                                r_out_dst   <= r_dst;
                                r_out_edge  <= 1'b1;
                                r_out_ovf   <= 1'b0;
                                r_out_last  <= 1'b0;
                            end
                            r_pend_valid <= 1'b1;
                            r_pend_src   <= r_cmp_idx;
                        end
                        if (r_rd_idx != r_dst) begin
                            r_cmp_v   <= 1'b1;
                            r_cmp_idx <= r_rd_idx;
                            r_rd_idx  <= r_rd_idx + IDX_W'(1);
                        end else begin
                            r_cmp_v <= 1'b0;
                        end
                    end
                    if (scan_done) begin
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    if (!r_pend_valid) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_src    <= r_pend_src;
                        r_out_dst    <= r_dst;
                        r_out_edge   <= 1'b1;
                        r_out_ovf    <= 1'b0;
                        r_out_last   <= 1'b1;
                        r_pend_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                S_OVFL: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_src   <= '0;
                        r_out_dst   <= '0;
                        r_out_edge  <= 1'b0;
                        r_out_ovf   <= 1'b1;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_hit.ready       = (r_state == S_IDLE);
    assign o_edge.valid      = r_out_valid;
    assign o_edge.src_index  = OUT_IDX_W'(r_out_src);
    assign o_edge.dst_index  = OUT_IDX_W'(r_out_dst);
    assign o_edge.edge_valid = r_out_edge;
    assign o_edge.overflow   = r_out_ovf;
    assign o_edge.last       = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_HITS))
        else $error("hit count beyond store capacity");

    a_word_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_edge != r_out_ovf))
        else $error("output word is neither a single edge nor a single status");

    a_ovfl_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ovf) |-> r_out_last)
        else $error("overflow word without last");

    a_pend_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_state == S_SCAN || r_state == S_FLUSH))
        else $error("pending edge outside a scan");

    a_cmp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_v |-> (r_cmp_idx < r_dst))
        else $error("compare index past the new hit");

    a_ovfl_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OVFL) |-> store_full)
        else $error("overflow path taken with room in the store");
endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for hit_graph_edge_builder_core. A queue-fed driver
// offers hit words, an input monitor predicts the edge and overflow words of
// each accepted hit, and an output monitor checks every output word in order.
// Phases sweep the angle windows, sender/receiver idling and back-pressure.
// ----------------------------------------------------------------------------
module tb;
    import hgeb_pkg::*;

    localparam int HIT_CAP     = 64;
    localparam int TAIL_CYCLES = HIT_CAP + 16;
    localparam int LONG_STALL  = 400;

    typedef struct packed {
        t_action                   action;
        logic [LAYER_W-1:0]        layer;
        logic signed [ANGLE_W-1:0] azimuth;
    } t_hit_word;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] src;
        logic [OUT_IDX_W-1:0] dst;
        logic                 is_edge;
        logic                 ovf;
        logic                 last;
    } t_pair_word;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    hgeb_in_if  hit_if ();
    hgeb_out_if edge_if ();

    hit_graph_edge_builder_core #(.MAX_HITS(HIT_CAP)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_hit      (hit_if.sink),
        .o_edge     (edge_if.source),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // predictor state
    logic [LAYER_W-1:0]        evt_layer [HIT_CAP];
    logic signed [ANGLE_W-1:0] evt_angle [HIT_CAP];
    int                        evt_count;
    logic [CFG_W-1:0]          tight_win;
    logic [CFG_W-1:0]          wide_win;

    t_hit_word  hit_backlog [$];
    t_pair_word exp_pairs [$];

    int  send_idle_pct;
    int  recv_idle_pct;
    int  stall_req;
    int  stall_seen;
    int  stall_left;
    bit  hit_taken;
    int  n_sent;
    int  n_accepted;
    int  n_hits;
    int  n_events;
    int  n_edges;
    int  n_overflows;
    int  n_settings;
    int  n_err;

    t_hit_word  cur_hit;
    t_pair_word got_exp;

    always #1 i_clk = ~i_clk;

    function automatic bit in_span(input logic [LAYER_W-1:0] l,
                                   input logic [LAYER_W-1:0] lo,
                                   input logic [LAYER_W-1:0] hi);
        return l >= lo && l <= hi;
    endfunction

    function automatic bit angle_near(input logic signed [ANGLE_W-1:0] a,
                                      input logic signed [ANGLE_W-1:0] b,
                                      input logic [CFG_W-1:0] w);
        int d;
        d = int'(a) - int'(b);
        if (d < 0) d = -d;
        return d < int'(w) || d > 65536 - int'(w);
    endfunction

    function automatic bit pair_links(input logic [LAYER_W-1:0] la,
                                      input logic signed [ANGLE_W-1:0] aa,
                                      input logic [LAYER_W-1:0] lb,
                                      input logic signed [ANGLE_W-1:0] ab);
        bit a_in;
        bit b_in;
        a_in = in_span(la, LYR_INNER_LO, LYR_INNER_HI);
        b_in = in_span(lb, LYR_INNER_LO, LYR_INNER_HI);
        if (a_in && b_in) return la != lb;
        if ((a_in && in_span(lb, LYR_DRIFT_LO, LYR_NEAR_HI)) ||
            (b_in && in_span(la, LYR_DRIFT_LO, LYR_NEAR_HI))) return 1'b1;
        if (in_span(la, LYR_DRIFT_LO, LYR_MID) && in_span(lb, LYR_DRIFT_LO, LYR_MID))
            return la != lb && angle_near(aa, ab, tight_win);
        if ((la == LYR_OUTER && in_span(lb, LYR_DRIFT_LO, LYR_DRIFT_HI)) ||
            (lb == LYR_OUTER && in_span(la, LYR_DRIFT_LO, LYR_DRIFT_HI)))
            return angle_near(aa, ab, wide_win);
        return 1'b0;
    endfunction

    task automatic predict_hit(input t_hit_word h);
        int         linked [$];
        t_pair_word w;
        if (h.action == ACT_NEW_EVENT) begin
            evt_count = 0;
            n_events++;
        end else if (evt_count >= HIT_CAP) begin
            w = '{src: '0, dst: '0, is_edge: 1'b0, ovf: 1'b1, last: 1'b1};
            exp_pairs = {exp_pairs, w};
            n_hits++;
            n_overflows++;
        end else begin
            for (int i = 0; i < evt_count; i++) begin
                if (pair_links(evt_layer[i], evt_angle[i], h.layer, h.azimuth))
                    linked = {linked, i};
            end
            foreach (linked[k]) begin
                w.src     = OUT_IDX_W'(linked[k]);
                w.dst     = OUT_IDX_W'(evt_count);
                w.is_edge = 1'b1;
                w.ovf     = 1'b0;
                w.last    = (k == linked.size() - 1);
                exp_pairs = {exp_pairs, w};
            end
            evt_layer[evt_count] = h.layer;
            evt_angle[evt_count] = h.azimuth;
            evt_count++;
            n_hits++;
        end
    endtask

    task automatic check_field(input string name, input logic [OUT_IDX_W-1:0] exp_v,
                               input logic [OUT_IDX_W-1:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            n_err++;
        end
    endtask

    // input side: predict on every accepted word
    always @(posedge i_clk) begin
        hit_taken = i_rst_n && hit_if.valid && hit_if.ready;
        if (hit_taken) begin
            predict_hit('{action: t_action'(hit_if.action), layer: hit_if.layer,
                          azimuth: hit_if.azimuth});
            n_accepted++;
        end
    end

    // output side: compare against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && edge_if.valid && edge_if.ready) begin
            if (exp_pairs.size() == 0) begin
                $error("output word src %0d dst %0d with nothing expected",
                       edge_if.src_index, edge_if.dst_index);
                n_err++;
            end else begin
                got_exp = exp_pairs.pop_front();
                check_field("src_index", got_exp.src, edge_if.src_index);
                check_field("dst_index", got_exp.dst, edge_if.dst_index);
                check_field("edge_valid", OUT_IDX_W'(got_exp.is_edge),
                            OUT_IDX_W'(edge_if.edge_valid));
                check_field("overflow", OUT_IDX_W'(got_exp.ovf),
                            OUT_IDX_W'(edge_if.overflow));
                check_field("last", OUT_IDX_W'(got_exp.last), OUT_IDX_W'(edge_if.last));
                n_edges += int'(got_exp.is_edge);
            end
        end
    end

    // driver: hold the word until taken, then offer the next or idle
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            hit_if.valid <= 1'b0;
        end else if (!hit_if.valid || hit_taken) begin
            if (hit_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                cur_hit = hit_backlog.pop_front();
                hit_if.valid   <= 1'b1;
                hit_if.action  <= cur_hit.action;
                hit_if.layer   <= cur_hit.layer;
                hit_if.azimuth <= cur_hit.azimuth;
            end else begin
                hit_if.valid <= 1'b0;
            end
        end
    end

    // receiver: random ready, with a long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            edge_if.ready <= 1'b0;
        end else if (stall_seen != stall_req) begin
            stall_seen    <= stall_req;
            stall_left    <= LONG_STALL;
            edge_if.ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            edge_if.ready <= 1'b0;
        end else begin
            edge_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic queue_word(input t_action a, input logic [LAYER_W-1:0] l,
                              input logic signed [ANGLE_W-1:0] az);
        t_hit_word h;
        h = '{action: a, layer: l, azimuth: az};
        hit_backlog = {hit_backlog, h};
        n_sent++;
    endtask

    function automatic logic [LAYER_W-1:0] rand_layer();
        if ($urandom_range(15) == 0)
            return $urandom_range(1) ? 5'd0 : LAYER_W'($urandom_range(26, 31));
        return LAYER_W'($urandom_range(1, 25));
    endfunction

    task automatic queue_event(input int n, input int spread);
        logic signed [ANGLE_W-1:0] base;
        base = ANGLE_W'($urandom);
        queue_word(ACT_NEW_EVENT, LAYER_W'($urandom), ANGLE_W'($urandom));
        for (int i = 0; i < n; i++) begin
            // drop in a stray event start now and then
            if ($urandom_range(11) == 0)
                queue_word(ACT_NEW_EVENT, LAYER_W'($urandom), ANGLE_W'($urandom));
            queue_word(ACT_ADD_HIT, rand_layer(),
                       base + ANGLE_W'(int'($urandom_range(2 * spread)) - spread));
        end
    endtask

    // fill the store, link the 64th hit to all drift hits, then overflow
    task automatic queue_fill_event(input int drift_pct);
        queue_word(ACT_NEW_EVENT, 5'd0, 16'sd0);
        for (int i = 0; i < HIT_CAP - 1; i++) begin
            if ($urandom_range(99) < drift_pct)
                queue_word(ACT_ADD_HIT, LAYER_W'($urandom_range(7, 18)), ANGLE_W'($urandom));
            else
                queue_word(ACT_ADD_HIT, $urandom_range(1) ? 5'd0
                           : LAYER_W'($urandom_range(26, 31)), ANGLE_W'($urandom));
        end
        queue_word(ACT_ADD_HIT, LAYER_W'($urandom_range(1, 6)), ANGLE_W'($urandom));
        queue_word(ACT_ADD_HIT, rand_layer(), ANGLE_W'($urandom));
        queue_word(ACT_ADD_HIT, rand_layer(), ANGLE_W'($urandom));
    endtask

    task automatic wait_idle();
        while (n_accepted != n_sent || exp_pairs.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_window(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_TIGHT_WIN) tight_win = val;
        else wide_win = val;
        n_settings++;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] tw, input logic [CFG_W-1:0] ww,
                             input int s_idle, input int r_idle, input int fill_pct,
                             input bit squeeze);
        int placed;
        int n;
        int spread;
        set_window(CFG_TIGHT_WIN, tw);
        set_window(CFG_WIDE_WIN, ww);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        placed = 0;
        if (squeeze) begin
            stall_req++;
            queue_event(20, 600);
            placed += 20;
        end
        if (fill_pct >= 0) begin
            queue_fill_event(fill_pct);
            placed += HIT_CAP + 2;
        end
        while (placed < 20) begin
            n = $urandom_range(2, 14);
            case ($urandom_range(3))
                0: spread = 200;
                1: spread = int'(tw);
                2: spread = 4096;
                default: spread = 32768;
            endcase
            queue_event(n, spread);
            placed += n;
        end
        wait_idle();
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = CFG_TIGHT_WIN;
        cfg_data       = '0;
        hit_if.valid   = 1'b0;
        hit_if.action  = ACT_ADD_HIT;
        hit_if.layer   = '0;
        hit_if.azimuth = '0;
        edge_if.ready  = 1'b0;
        evt_count      = 0;
        tight_win      = TIGHT_WIN_RST;
        wide_win       = WIDE_WIN_RST;
        send_idle_pct  = 32;
        recv_idle_pct  = 66;
        stall_req      = 0;
        stall_seen     = 0;
        stall_left     = 0;
        hit_taken      = 1'b0;
        n_sent         = 0;
        n_accepted     = 0;
        n_hits         = 0;
        n_events       = 0;
        n_edges        = 0;
        n_overflows    = 0;
        n_settings     = 0;
        n_err          = 0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // rule corners, window bounds and angle wrap under reset windows
        queue_word(ACT_NEW_EVENT, 5'd31, -16'sd1);
        queue_word(ACT_ADD_HIT, 5'd1, 16'sd0);
        queue_word(ACT_ADD_HIT, 5'd1, 16'sd100);
        queue_word(ACT_ADD_HIT, 5'd6, 16'sh8000);
        queue_word(ACT_ADD_HIT, 5'd7, 16'sd8191);
        queue_word(ACT_ADD_HIT, 5'd18, 16'sd32767);
        queue_word(ACT_ADD_HIT, 5'd19, 16'sd0);
        queue_word(ACT_ADD_HIT, 5'd24, -16'sd8192);
        queue_word(ACT_ADD_HIT, 5'd23, 16'sd0);
        queue_word(ACT_ADD_HIT, 5'd25, 16'sd16383);
        queue_word(ACT_ADD_HIT, 5'd25, -16'sd16384);
        queue_word(ACT_ADD_HIT, 5'd0, 16'sd0);
        queue_word(ACT_ADD_HIT, 5'd26, 16'sd0);
        queue_word(ACT_ADD_HIT, 5'd31, -16'sd1);
        queue_word(ACT_ADD_HIT, 5'd8, 16'sh8000);
        queue_word(ACT_ADD_HIT, 5'd1, 16'sd5);
        queue_word(ACT_NEW_EVENT, 5'd0, 16'sd0);
        queue_word(ACT_ADD_HIT, 5'd25, 16'sd0);
        queue_word(ACT_ADD_HIT, 5'd23, -16'sd16383);
        queue_word(ACT_ADD_HIT, 5'd12, 16'sd16384);
        queue_word(ACT_ADD_HIT, 5'd24, 16'sd8192);
        queue_word(ACT_ADD_HIT, 5'd9, 16'sd16383);
        wait_idle();

        run_phase(TIGHT_WIN_RST, WIDE_WIN_RST, 32, 66, -1, 1'b0);
        run_phase(16'd0, 16'd32768, 32, 66, 100, 1'b0);
        run_phase(16'd32768, 16'd0, 66, 32, 20, 1'b0);
        run_phase(16'd1, 16'd65535, 66, 32, -1, 1'b0);
        run_phase(CFG_W'($urandom_range(32768)), CFG_W'($urandom_range(32768)),
                  0, 0, -1, 1'b1);
        run_phase(TIGHT_WIN_RST, WIDE_WIN_RST, 0, 0, -1, 1'b0);

        $display("Covered %0d hits over %0d events under %0d window writes.",
                 n_hits, n_events, n_settings);
        $display("Checked %0d edge words and %0d overflow words, %0d mismatches.",
                 n_edges, n_overflows, n_err);
        if (n_err == 0 && exp_pairs.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: hit_graph_edge_builder_core.f
rtl/hgeb_pkg.sv
rtl/hgeb_in_if.sv
rtl/hgeb_out_if.sv
rtl/hgeb_ram.sv
rtl/hit_graph_edge_builder_core.sv
bench/tb.sv
